// ===== design/i2c_write_frame_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// I2C write frame sequencer assertion macros
// Shared wrappers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef I2C_WRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_WRITE_FRAME_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled in reset.
`define I2CW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled in reset.
`define I2CW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/i2cw_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C write frame sequencer package
// Types, constants and register indexes shared by the sequencer files.
// ----------------------------------------------------------------------------
package i2cw_pkg;

  localparam int unsigned DelayW    = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PhaseW    = 7;
  localparam int unsigned FrameW    = 3 * ByteW;
  localparam int unsigned CfgDataW  = DelayW;

  localparam logic [DelayW-1:0] DelayReset   = 16'd25;
  localparam logic [ByteW-1:0]  AddrReset    = 8'h78;
  localparam logic [ByteW-1:0]  CtrlCommand  = 8'h00;
  localparam logic [ByteW-1:0]  CtrlData     = 8'h40;

  localparam logic [PhaseW-1:0] PhStartHigh  = 7'd0;
  localparam logic [PhaseW-1:0] PhStartLow   = 7'd1;
  localparam logic [PhaseW-1:0] PhStartClk   = 7'd2;
  localparam logic [PhaseW-1:0] PhFirstBit   = 7'd3;
  localparam logic [PhaseW-1:0] PhStopLow    = 7'd84;
  localparam logic [PhaseW-1:0] PhLast       = 7'd85;

  localparam logic [1:0] SubLast  = 2'd2;
  localparam logic [1:0] SubHigh  = 2'd1;
  localparam logic [3:0] SlotAck  = 4'd8;

  typedef enum logic [0:0] {
    CFG_DELAY_TICKS    = 1'b0,
    CFG_DEVICE_ADDRESS = 1'b1
  } cfg_idx_e;

  // Position inside the three byte fields of a frame.
  typedef struct packed {
    logic [1:0] byte_sel;
    logic [3:0] slot;
    logic [1:0] sub;
  } bit_pos_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } lines_t;

endpackage

// ===== design/i2cw_req_if.sv =====
// ----------------------------------------------------------------------------
// I2C write frame sequencer request channel
// Valid/ready channel that carries one tick or write request per item.
// ----------------------------------------------------------------------------
interface i2cw_req_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [i2cw_pkg::ByteW-1:0]     data_byte;
  logic                           is_data;

  modport source (output valid, output op, output data_byte, output is_data, input ready);
  modport sink   (input valid, input op, input data_byte, input is_data, output ready);
endinterface

// ===== design/i2cw_res_if.sv =====
// ----------------------------------------------------------------------------
// I2C write frame sequencer result channel
// Valid/ready channel that carries the bus levels and status of one item.
// ----------------------------------------------------------------------------
interface i2cw_res_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda;
  logic busy_res;
  logic accepted;

  modport source (output valid, output scl, output sda, output busy_res, output accepted,
                  input ready);
  modport sink   (input valid, input scl, input sda, input busy_res, input accepted,
                  output ready);
endinterface

// ===== design/i2c_write_frame_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// I2C write frame sequencer
// Bit-banged I2C master that sends one three-byte write frame per request.
// ----------------------------------------------------------------------------
// Each item on req_i is one time tick. With op high and no frame running,
// the item starts a frame (start, device address, control byte, data byte,
// stop), each byte followed by an unsampled acknowledge clock. The frame
// has 86 phases of delay_ticks items each (one item when it is zero); a
// request while busy is refused and treated as a plain tick.
// Every item yields exactly one item on res_o with the SCL and SDA levels
// for that tick, the busy flag and whether the request was taken.
// Each result is registered and valid in the cycle after acceptance; one item is
// taken every cycle while res_o is ready. A stalled result stays in the
// output register; req_i.ready falls only while that register is full and
// not being drained, so no item is lost.
// Reset ends any running frame, sets both lines high and restores delay_ticks to
// 25 and device_address to 0x78. Configuration is written through cfg_we_i
// with cfg_idx_i selecting the register.
// ----------------------------------------------------------------------------
module i2c_write_frame_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [i2cw_pkg::CfgDataW-1:0] cfg_wdata_i,
  i2cw_req_if.sink                      req_i,
  i2cw_res_if.source                    res_o
);

  logic [i2cw_pkg::DelayW-1:0] delay_q;
  logic [i2cw_pkg::ByteW-1:0]  addr_q;
  logic [i2cw_pkg::PhaseW-1:0] phase_q, phase_d, phase_eff;
  logic [i2cw_pkg::DelayW-1:0] tick_q, tick_d, tick_eff, tick_inc, limit;
  logic [i2cw_pkg::FrameW-1:0] frame_q;
  i2cw_pkg::bit_pos_t          pos_q, pos_d, pos_eff;
  logic                        busy_q, busy_d, busy_eff;
  logic                        scl_q, sda_q;
  logic                        res_valid_q;
  logic                        res_scl_q, res_sda_q, res_busy_q, res_acc_q;
  logic                        acc, start, ph_end;
  i2cw_pkg::lines_t            lines;
  logic [i2cw_pkg::ByteW-1:0]  ctrl;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign acc         = req_i.valid && req_i.ready;
  assign start       = acc && req_i.op && !busy_q;

  assign busy_eff  = busy_q || start;
  assign phase_eff = start ? '0 : phase_q;
  assign tick_eff  = start ? '0 : tick_q;
  assign pos_eff   = start ? '0 : pos_q;
  assign ctrl      = req_i.is_data ? i2cw_pkg::CtrlData : i2cw_pkg::CtrlCommand;

  i2cw_phase_decode u_decode (
    .phase_i (phase_eff),
    .pos_i   (pos_eff),
    .frame_i (frame_q),
    .lines_o (lines)
  );

  assign limit    = (delay_q == '0) ? i2cw_pkg::DelayW'(1) : delay_q;
  assign tick_inc = tick_eff + i2cw_pkg::DelayW'(1);
  assign ph_end   = (tick_inc >= limit) || (tick_inc == '0);

  always_comb begin
    phase_d = phase_eff;
    tick_d  = tick_inc;
    pos_d   = pos_eff;
    busy_d  = busy_eff;
    if (ph_end) begin
      tick_d = '0;
      if (phase_eff == i2cw_pkg::PhLast) begin
        phase_d = '0;
        busy_d  = 1'b0;
      end else begin
        phase_d = phase_eff + i2cw_pkg::PhaseW'(1);
      end
      if (phase_eff >= i2cw_pkg::PhFirstBit) begin
        if (pos_eff.sub == i2cw_pkg::SubLast) begin
          pos_d.sub = '0;
          if (pos_eff.slot == i2cw_pkg::SlotAck) begin
            pos_d.slot     = '0;
            pos_d.byte_sel = pos_eff.byte_sel + 2'd1;
          end else begin
            pos_d.slot = pos_eff.slot + 4'd1;
          end
        end else begin
          pos_d.sub = pos_eff.sub + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= i2cw_pkg::DelayReset;
      addr_q  <= i2cw_pkg::AddrReset;
    end else if (cfg_we_i) begin
      unique case (i2cw_pkg::cfg_idx_e'(cfg_idx_i))
        i2cw_pkg::CFG_DELAY_TICKS:    delay_q <= cfg_wdata_i;
        i2cw_pkg::CFG_DEVICE_ADDRESS: addr_q  <= cfg_wdata_i[i2cw_pkg::ByteW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      tick_q  <= '0;
      pos_q   <= '0;
      busy_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (acc && busy_eff) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      pos_q   <= pos_d;
      busy_q  <= busy_d;
      scl_q   <= lines.scl;
      sda_q   <= lines.sda;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      frame_q <= {addr_q, ctrl, req_i.data_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (acc) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_scl_q  <= busy_eff ? lines.scl : scl_q;
      res_sda_q  <= busy_eff ? lines.sda : sda_q;
      res_busy_q <= busy_eff;
      res_acc_q  <= start;
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.scl      = res_scl_q;
  assign res_o.sda      = res_sda_q;
  assign res_o.busy_res = res_busy_q;
  assign res_o.accepted = res_acc_q;

endmodule

// ===== design/i2cw_phase_decode.sv =====
// ----------------------------------------------------------------------------
// I2C write frame sequencer phase decoder
// Maps the current phase and bit position to the SCL and SDA levels.
// ----------------------------------------------------------------------------
module i2cw_phase_decode (
  input  logic [i2cw_pkg::PhaseW-1:0] phase_i,
  input  i2cw_pkg::bit_pos_t          pos_i,
  input  logic [i2cw_pkg::FrameW-1:0] frame_i,
  output i2cw_pkg::lines_t            lines_o
);

  logic [i2cw_pkg::ByteW-1:0] octet;
  logic                       data_bit;

  always_comb begin
    unique case (pos_i.byte_sel)
      2'd0:    octet = frame_i[23:16];
      2'd1:    octet = frame_i[15:8];
      default: octet = frame_i[7:0];
    endcase
    data_bit = octet[3'd7 - pos_i.slot[2:0]];
  end

  always_comb begin
    priority if (phase_i == i2cw_pkg::PhStartHigh) begin
      lines_o = '{scl: 1'b1, sda: 1'b1};
    end else if (phase_i == i2cw_pkg::PhStartLow) begin
      lines_o = '{scl: 1'b1, sda: 1'b0};
    end else if (phase_i == i2cw_pkg::PhStartClk) begin
      lines_o = '{scl: 1'b0, sda: 1'b0};
    end else if (phase_i == i2cw_pkg::PhStopLow) begin
      lines_o = '{scl: 1'b1, sda: 1'b0};
    end else if (phase_i >= i2cw_pkg::PhLast) begin
      lines_o = '{scl: 1'b1, sda: 1'b1};
    end else begin
      lines_o.scl = (pos_i.sub == i2cw_pkg::SubHigh);
      lines_o.sda = (pos_i.slot == i2cw_pkg::SlotAck) ? 1'b1 : data_bit;
    end
  end

endmodule

// ===== design/i2cw_checker.sv =====
// ----------------------------------------------------------------------------
// I2C write frame sequencer port checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_write_frame_sequencer_unit_assert.svh"

module i2cw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic res_scl_i,
  input logic res_sda_i,
  input logic res_busy_i,
  input logic res_acc_i
);

  `I2CW_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i, "result dropped while stalled")
  `I2CW_ASSERT_IMP(a_acc_busy, res_valid_i && res_acc_i, res_busy_i, "started frame not shown busy")
  `I2CW_ASSERT_IMP(a_idle_high, res_valid_i && !res_busy_i, res_scl_i && res_sda_i, "bus not idle high")

endmodule

bind i2c_write_frame_sequencer_unit i2cw_checker u_i2cw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_scl_i   (res_o.scl),
  .res_sda_i   (res_o.sda),
  .res_busy_i  (res_o.busy_res),
  .res_acc_i   (res_o.accepted)
);

// ===== sim/i2c_write_frame_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// I2C write frame sequencer testbench
// Drives tick and write-request items into the sequencer with random gaps and
// output stalls, tracks the expected SCL/SDA levels, busy and accept flags of
// every item in a scoreboard, and changes the delay and address registers
// between bursts, mid-frame included.
// ----------------------------------------------------------------------------
module i2c_write_frame_sequencer_unit_tb;
  import i2cw_pkg::*;

  localparam int unsigned PhaseCount   = 86;
  localparam int unsigned PhasesPerByte = 27;
  localparam int unsigned AckFirstPhase = 24;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned ItemsPerBurst = 285;
  localparam int unsigned HoldOffAt    = 400;
  localparam int unsigned HoldOffLen   = 60;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
    logic took;
  } tick_levels_t;

  class bus_level_scoreboard;
    logic [DelayW-1:0] delay_ticks;
    logic [ByteW-1:0]  device_address;
    logic [PhaseW-1:0] phase;
    logic [DelayW-1:0] tick_count;
    logic [FrameW-1:0] frame_bits;
    logic              busy;
    logic              scl_level;
    logic              sda_level;
    tick_levels_t      expected_levels[$];
    int unsigned       checked;
    int unsigned       mismatches;

    function new();
      delay_ticks    = DelayReset;
      device_address = AddrReset;
      phase          = '0;
      tick_count     = '0;
      frame_bits     = '0;
      busy           = 1'b0;
      scl_level      = 1'b1;
      sda_level      = 1'b1;
      checked        = 0;
      mismatches     = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_DELAY_TICKS:    delay_ticks = value[DelayW-1:0];
        CFG_DEVICE_ADDRESS: device_address = value[ByteW-1:0];
        default: ;
      endcase
    endfunction

    function void drive_phase_levels();
      int          q;
      int          which;
      int          rem;
      logic [7:0]  octet;
      if (phase == PhStartHigh) begin
        scl_level = 1'b1;
        sda_level = 1'b1;
      end else if (phase == PhStartLow) begin
        scl_level = 1'b1;
        sda_level = 1'b0;
      end else if (phase == PhStartClk) begin
        scl_level = 1'b0;
        sda_level = 1'b0;
      end else if (phase == PhStopLow) begin
        scl_level = 1'b1;
        sda_level = 1'b0;
      end else if (phase >= PhLast) begin
        scl_level = 1'b1;
        sda_level = 1'b1;
      end else begin
        q     = int'(phase) - int'(PhFirstBit);
        which = q / PhasesPerByte;
        rem   = q % PhasesPerByte;
        octet = frame_bits[8*(2-which) +: 8];
        if (rem < AckFirstPhase) begin
          sda_level = octet[7 - rem/3];
          scl_level = ((rem % 3) == 1);
        end else begin
          sda_level = 1'b1;
          scl_level = ((rem - AckFirstPhase) == 1);
        end
      end
    endfunction

    function void take_tick(logic op, logic [ByteW-1:0] data_byte, logic is_data);
      tick_levels_t      want;
      logic [ByteW-1:0]  ctrl;
      logic [DelayW-1:0] limit;
      want.took = 1'b0;
      want.busy = 1'b0;
      if (op && !busy) begin
        ctrl       = is_data ? CtrlData : CtrlCommand;
        frame_bits = {device_address, ctrl, data_byte};
        busy       = 1'b1;
        phase      = '0;
        tick_count = '0;
        want.took  = 1'b1;
      end
      if (busy) begin
        limit = (delay_ticks == '0) ? DelayW'(1) : delay_ticks;
        drive_phase_levels();
        want.busy  = 1'b1;
        tick_count = tick_count + 1'b1;
        if (tick_count >= limit || tick_count == '0) begin
          tick_count = '0;
          phase      = phase + 1'b1;
          if (phase >= PhaseCount) begin
            phase = '0;
            busy  = 1'b0;
          end
        end
      end
      want.scl = scl_level;
      want.sda = sda_level;
      expected_levels.push_back(want);
    endfunction

    function void note_mismatch(string what, logic want, logic got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch on %s of result %0d: expected %b, got %b",
                 $time, what, checked, want, got);
      end
    endfunction

    function void check_levels(tick_levels_t got);
      tick_levels_t want;
      checked++;
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result %0d arrived with nothing expected: got %b",
                   $time, checked, got);
        end
        return;
      end
      want = expected_levels.pop_front();
      if (got.scl !== want.scl) note_mismatch("scl", want.scl, got.scl);
      if (got.sda !== want.sda) note_mismatch("sda", want.sda, got.sda);
      if (got.busy !== want.busy) note_mismatch("busy_res", want.busy, got.busy);
      if (got.took !== want.took) note_mismatch("accepted", want.took, got.took);
    endfunction

    function int unsigned pending_count();
      return expected_levels.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  bit                  steady_run = 1'b0;
  bus_level_scoreboard sb;

  i2cw_req_if req_bus ();
  i2cw_res_if res_bus ();

  i2c_write_frame_sequencer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_bus),
    .res_o      (res_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_tick(logic op, logic [ByteW-1:0] data_byte, logic is_data);
    @(negedge clk_i);
    while (!steady_run && $urandom_range(0, 99) < 9) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.op        <= op;
    req_bus.data_byte <= data_byte;
    req_bus.is_data   <= is_data;
    do begin
      @(posedge clk_i);
    end while (req_bus.ready !== 1'b1);
    sb.take_tick(op, data_byte, is_data);
  endtask

  task automatic send_random_tick();
    send_tick($urandom_range(0, 5) == 0, ByteW'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [DelayW-1:0] delay, logic [ByteW-1:0] addr);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DELAY_TICKS;
    cfg_wdata <= delay;
    sb.set_reg(CFG_DELAY_TICKS, delay);
    @(negedge clk_i);
    cfg_idx   <= CFG_DEVICE_ADDRESS;
    cfg_wdata <= CfgDataW'(addr);
    sb.set_reg(CFG_DEVICE_ADDRESS, CfgDataW'(addr));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : result_ready_driver
    int unsigned hold_left = 0;
    bit          held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sb.checked >= HoldOffAt) begin
        held      = 1'b1;
        hold_left = HoldOffLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= steady_run || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  initial begin : result_monitor
    tick_levels_t got;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        got.scl  = res_bus.scl;
        got.sda  = res_bus.sda;
        got.busy = res_bus.busy_res;
        got.took = res_bus.accepted;
        sb.check_levels(got);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    sb                = new();
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_DELAY_TICKS;
    cfg_wdata         = '0;
    req_bus.valid     = 1'b0;
    req_bus.op        = 1'b0;
    req_bus.data_byte = '0;
    req_bus.is_data   = 1'b0;
    res_bus.ready     = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values: an idle tick, a data frame, then a refused request.
    send_tick(1'b0, 8'h00, 1'b0);
    send_tick(1'b1, 8'hFF, 1'b1);
    send_tick(1'b1, 8'h00, 1'b0);
    repeat (5) send_tick(1'b0, ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    drain_results();

    // A zero delay behaves as one item per phase.
    set_regs('0, 8'h00);
    repeat (4) send_tick(1'b0, 8'hA5, 1'b1);
    drain_results();

    // Largest delay mid-frame, then a delay below the running count.
    set_regs(16'hFFFF, 8'hFF);
    repeat (3) send_tick(1'b0, 8'h5A, 1'b0);
    drain_results();
    set_regs(16'd2, 8'hFF);
    repeat (3) send_tick(1'b1, 8'h00, 1'b0);
    drain_results();

    for (int burst = 0; burst < 4; burst++) begin
      case (burst)
        0: set_regs(16'd1, 8'hFF);
        1: set_regs(16'd2, 8'h00);
        2: set_regs(16'd1, ByteW'($urandom_range(0, 255)));
        default: set_regs(DelayW'($urandom_range(1, 4)), ByteW'($urandom_range(0, 255)));
      endcase
      steady_run = (burst == 2);
      repeat (ItemsPerBurst) send_random_tick();
      drain_results();
      steady_run = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/i2cw_pkg.sv
design/i2cw_req_if.sv
design/i2cw_res_if.sv
design/i2cw_phase_decode.sv
design/i2c_write_frame_sequencer_unit.sv
design/i2cw_checker.sv
sim/i2c_write_frame_sequencer_unit_tb.sv
